FILE: design/gbrl_pkg.sv
`default_nettype none

package gbrl_pkg;

  // Geometry limits and fixed-point constants
  localparam int unsigned MaxWidth    = 4096;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned DimW        = 13;
  localparam int unsigned ColW        = $clog2(MaxWidth);
  localparam int unsigned RowW        = $clog2(MaxHeight);
  localparam int unsigned LogOffsetQ8 = 4259;  // 3 * ln(256) in Q.8
  localparam int unsigned MaskOn      = 255;
  localparam int unsigned RoundHalf   = 128;

  localparam int unsigned SqW     = 16;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned PixW    = 32;
  localparam int unsigned RowAccW = 48;
  localparam int unsigned FrmAccW = 56;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode        = 3'd0,
    CfgFrameWidth  = 3'd1,
    CfgFrameHeight = 3'd2,
    CfgLogNormSum  = 3'd3,
    CfgInvVarCh0   = 3'd4,
    CfgInvVarCh1   = 3'd5,
    CfgInvVarCh2   = 3'd6,
    CfgMaskThresh  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeRowSum    = 2'd0,
    ModeRowOffset = 2'd1,
    ModeMask      = 2'd2,
    ModeSpare     = 2'd3
  } mode_e;

  typedef struct packed {
    logic [7:0] pix_ch0;
    logic [7:0] pix_ch1;
    logic [7:0] pix_ch2;
    logic [7:0] bg_ch0;
    logic [7:0] bg_ch1;
    logic [7:0] bg_ch2;
  } in_t;

  typedef struct packed {
    logic signed [PixW-1:0]    pixel_value;
    logic signed [RowAccW-1:0] row_cumulative;
    logic signed [FrmAccW-1:0] frame_total;
    logic                      row_end;
    logic                      frame_end;
  } out_t;

  typedef struct packed {
    mode_e                     mode;
    logic [DimW-1:0]           frame_width;
    logic [DimW-1:0]           frame_height;
    logic signed [15:0]        log_norm_sum;
    logic [15:0]               inv_var_ch0;
    logic [15:0]               inv_var_ch1;
    logic [15:0]               inv_var_ch2;
    logic signed [15:0]        mask_threshold;
  } cfg_t;

  // Stage load enables shared by the lanes, the merge and the accumulator
  typedef struct packed {
    logic sq_en;
    logic prod_en;
    logic sum_en;
    logic acc_en;
  } adv_t;

endpackage

`default_nettype wire

FILE: design/gbrl_lane.sv
`default_nettype none

// One colour channel: squared difference, then scale by the inverse variance.
module gbrl_lane (
  input  wire logic                          clk_i,
  input  wire gbrl_pkg::adv_t                adv_i,
  input  wire logic [7:0]                    pix_i,
  input  wire logic [7:0]                    bg_i,
  input  wire logic [15:0]                   inv_var_i,
  output logic      [gbrl_pkg::ProdW-1:0]    prod_o
);

  logic signed [8:0]                diff;
  logic signed [17:0]               sq_full;
  logic [gbrl_pkg::SqW-1:0]         sq_d, sq_q;
  logic [gbrl_pkg::ProdW-1:0]       prod_d, prod_q;

  always_comb begin
    diff    = $signed({1'b0, pix_i}) - $signed({1'b0, bg_i});
    sq_full = 18'(diff) * 18'(diff);
    sq_d    = sq_full[gbrl_pkg::SqW-1:0];
    prod_d  = gbrl_pkg::ProdW'(sq_q) * gbrl_pkg::ProdW'(inv_var_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.sq_en) begin
      sq_q <= sq_d;
    end
    if (adv_i.prod_en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: design/gbrl_merge.sv
`default_nettype none

// Combine the three lane products: round Q.16 to Q.8, negate with the normalisation.
module gbrl_merge (
  input  wire logic                              clk_i,
  input  wire gbrl_pkg::adv_t                    adv_i,
  input  wire logic [gbrl_pkg::ProdW-1:0]        prod0_i,
  input  wire logic [gbrl_pkg::ProdW-1:0]        prod1_i,
  input  wire logic [gbrl_pkg::ProdW-1:0]        prod2_i,
  input  wire logic signed [15:0]                log_norm_sum_i,
  output logic signed [gbrl_pkg::PixW-1:0]       loglik_o
);

  localparam int unsigned SumW = gbrl_pkg::ProdW + 2;

  logic [SumW-1:0]                   sum;
  logic [SumW-9:0]                   scaled;
  logic signed [gbrl_pkg::PixW-1:0]  loglik_d, loglik_q;

  always_comb begin
    sum = {2'b00, prod0_i} + {2'b00, prod1_i} + {2'b00, prod2_i}
        + SumW'(gbrl_pkg::RoundHalf);
    scaled   = sum[SumW-1:8];
    loglik_d = -{{(gbrl_pkg::PixW-16){log_norm_sum_i[15]}}, log_norm_sum_i}
             - {{(gbrl_pkg::PixW-(SumW-8)){1'b0}}, scaled};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.sum_en) begin
      loglik_q <= loglik_d;
    end
  end

  assign loglik_o = loglik_q;

endmodule

`default_nettype wire

FILE: design/gbrl_accum.sv
`default_nettype none

// Raster position, saturating row and frame sums, mask and the output register.
module gbrl_accum (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire gbrl_pkg::adv_t                    adv_i,
  input  wire gbrl_pkg::cfg_t                    cfg_i,
  input  wire logic signed [gbrl_pkg::PixW-1:0]  loglik_i,
  output gbrl_pkg::out_t                         out_o
);

  localparam int unsigned RowSumW = gbrl_pkg::RowAccW + 1;
  localparam int unsigned FrmSumW = gbrl_pkg::FrmAccW + 1;

  logic [gbrl_pkg::ColW-1:0]            col_d, col_q;
  logic [gbrl_pkg::RowW-1:0]            row_d, row_q;
  logic signed [gbrl_pkg::RowAccW-1:0]  racc_d, racc_q;
  logic signed [gbrl_pkg::FrmAccW-1:0]  facc_d, facc_q;
  gbrl_pkg::out_t                       out_d, out_q;

  logic [gbrl_pkg::DimW-1:0]            w_eff, h_eff, w_last, h_last;
  logic                                 row_end, frame_end;
  logic signed [gbrl_pkg::PixW:0]       row_add;
  logic signed [RowSumW-1:0]            row_sum;
  logic signed [FrmSumW-1:0]            frm_sum;
  logic signed [gbrl_pkg::RowAccW-1:0]  row_sat;
  logic signed [gbrl_pkg::FrmAccW-1:0]  frm_sat;
  logic signed [gbrl_pkg::PixW-1:0]     thresh;

  always_comb begin
    // Clamp geometry: zero counts as one, cap at the maximum
    priority if (cfg_i.frame_width == '0) begin
      w_eff = gbrl_pkg::DimW'(1);
    end else if (cfg_i.frame_width > gbrl_pkg::DimW'(gbrl_pkg::MaxWidth)) begin
      w_eff = gbrl_pkg::DimW'(gbrl_pkg::MaxWidth);
    end else begin
      w_eff = cfg_i.frame_width;
    end
    priority if (cfg_i.frame_height == '0) begin
      h_eff = gbrl_pkg::DimW'(1);
    end else if (cfg_i.frame_height > gbrl_pkg::DimW'(gbrl_pkg::MaxHeight)) begin
      h_eff = gbrl_pkg::DimW'(gbrl_pkg::MaxHeight);
    end else begin
      h_eff = cfg_i.frame_height;
    end
    w_last    = w_eff - gbrl_pkg::DimW'(1);
    h_last    = h_eff - gbrl_pkg::DimW'(1);
    row_end   = gbrl_pkg::DimW'(col_q) >= w_last;
    frame_end = row_end && (gbrl_pkg::DimW'(row_q) >= h_last);

    row_add = {loglik_i[gbrl_pkg::PixW-1], loglik_i};
    if (cfg_i.mode == gbrl_pkg::ModeRowOffset) begin
      row_add = row_add + (gbrl_pkg::PixW+1)'(gbrl_pkg::LogOffsetQ8);
    end

    row_sum = {racc_q[gbrl_pkg::RowAccW-1], racc_q}
            + {{(RowSumW-gbrl_pkg::PixW-1){row_add[gbrl_pkg::PixW]}}, row_add};
    frm_sum = {facc_q[gbrl_pkg::FrmAccW-1], facc_q}
            + {{(FrmSumW-gbrl_pkg::PixW){loglik_i[gbrl_pkg::PixW-1]}}, loglik_i};

    // Clip on overflow: the carry-out sign differs from the result sign
    if (row_sum[RowSumW-1] != row_sum[RowSumW-2]) begin
      row_sat = {row_sum[RowSumW-1], {(gbrl_pkg::RowAccW-1){~row_sum[RowSumW-1]}}};
    end else begin
      row_sat = row_sum[gbrl_pkg::RowAccW-1:0];
    end
    if (frm_sum[FrmSumW-1] != frm_sum[FrmSumW-2]) begin
      frm_sat = {frm_sum[FrmSumW-1], {(gbrl_pkg::FrmAccW-1){~frm_sum[FrmSumW-1]}}};
    end else begin
      frm_sat = frm_sum[gbrl_pkg::FrmAccW-1:0];
    end

    thresh = {{(gbrl_pkg::PixW-16){cfg_i.mask_threshold[15]}}, cfg_i.mask_threshold};

    out_d.row_cumulative = row_sat;
    out_d.frame_total    = frm_sat;
    out_d.row_end        = row_end;
    out_d.frame_end      = frame_end;
    if (cfg_i.mode == gbrl_pkg::ModeMask) begin
      out_d.pixel_value = (loglik_i < thresh) ? gbrl_pkg::PixW'(gbrl_pkg::MaskOn) : '0;
    end else begin
      out_d.pixel_value = loglik_i;
    end

    col_d  = col_q;
    row_d  = row_q;
    racc_d = racc_q;
    facc_d = facc_q;
    if (adv_i.acc_en) begin
      racc_d = row_sat;
      facc_d = frm_sat;
      col_d  = col_q + gbrl_pkg::ColW'(1);
      if (row_end) begin
        col_d  = '0;
        racc_d = '0;
        row_d  = row_q + gbrl_pkg::RowW'(1);
        if (frame_end) begin
          row_d  = '0;
          facc_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      racc_q <= '0;
      facc_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      racc_q <= racc_d;
      facc_q <= facc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.acc_en) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

FILE: design/gaussian_background_row_loglik.sv
// Four register stages: squares, products, log-likelihood and the output register. One pixel
// per clock unless out_stall_i holds the pipeline; the three channel lanes and the merge are
// fully pipelined, the row and frame accumulators close their loop within the final stage.
// Reset (rst_ni low, asynchronous): pipeline emptied, raster counters and sums cleared,
// configuration registers return to mode 0, 640 x 480, zero normalisation, 404, -5120.
`default_nettype none

module gaussian_background_row_loglik (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // pixel input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire gbrl_pkg::in_t                     in_data_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output gbrl_pkg::out_t                         out_data_o,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [gbrl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [gbrl_pkg::CfgDataW-1:0]     cfg_data_i
);

  gbrl_pkg::cfg_t cfg_d, cfg_q;

  // Stage valid flags: squares, products, log-likelihood, output register
  logic v1_d, v1_q, v2_d, v2_q, v3_d, v3_q, v4_d, v4_q;
  logic adv1, adv2, adv3, adv4;
  gbrl_pkg::adv_t adv;

  logic [gbrl_pkg::ProdW-1:0]       prod0, prod1, prod2;
  logic signed [gbrl_pkg::PixW-1:0] loglik;

  // ---------------------------------------------------------------------------
  // Configuration: always ready; the user, not the block, must see that it is written only while the pipeline is idle
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (gbrl_pkg::cfg_idx_e'(cfg_index_i))
        gbrl_pkg::CfgMode:        cfg_d.mode           = gbrl_pkg::mode_e'(cfg_data_i[1:0]);
        gbrl_pkg::CfgFrameWidth:  cfg_d.frame_width    = cfg_data_i[gbrl_pkg::DimW-1:0];
        gbrl_pkg::CfgFrameHeight: cfg_d.frame_height   = cfg_data_i[gbrl_pkg::DimW-1:0];
        gbrl_pkg::CfgLogNormSum:  cfg_d.log_norm_sum   = $signed(cfg_data_i);
        gbrl_pkg::CfgInvVarCh0:   cfg_d.inv_var_ch0    = cfg_data_i;
        gbrl_pkg::CfgInvVarCh1:   cfg_d.inv_var_ch1    = cfg_data_i;
        gbrl_pkg::CfgInvVarCh2:   cfg_d.inv_var_ch2    = cfg_data_i;
        gbrl_pkg::CfgMaskThresh:  cfg_d.mask_threshold = $signed(cfg_data_i);
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode           <= gbrl_pkg::ModeRowSum;
      cfg_q.frame_width    <= gbrl_pkg::DimW'(640);
      cfg_q.frame_height   <= gbrl_pkg::DimW'(480);
      cfg_q.log_norm_sum   <= '0;
      cfg_q.inv_var_ch0    <= 16'd404;
      cfg_q.inv_var_ch1    <= 16'd404;
      cfg_q.inv_var_ch2    <= 16'd404;
      cfg_q.mask_threshold <= -16'sd5120;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow: a stage advances when it is empty or the next one advances.
  // Stall back-propagates from the output register in one combinational chain.
  // ---------------------------------------------------------------------------
  always_comb begin
    adv4 = !v4_q || !out_stall_i;
    adv3 = !v3_q || adv4;
    adv2 = !v2_q || adv3;
    adv1 = !v1_q || adv2;

    v1_d = adv1 ? in_valid_i : v1_q;
    v2_d = adv2 ? v1_q : v2_q;
    v3_d = adv3 ? v2_q : v3_q;
    v4_d = adv4 ? v3_q : v4_q;

    adv.sq_en   = adv1 && in_valid_i;
    adv.prod_en = adv2 && v1_q;
    adv.sum_en  = adv3 && v2_q;
    adv.acc_en  = adv4 && v3_q;  // commit one pixel to the raster state
  end

  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel lanes, one per colour channel
  // ---------------------------------------------------------------------------
  gbrl_lane u_lane0 (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .pix_i     (in_data_i.pix_ch0),
    .bg_i      (in_data_i.bg_ch0),
    .inv_var_i (cfg_q.inv_var_ch0),
    .prod_o    (prod0)
  );

  gbrl_lane u_lane1 (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .pix_i     (in_data_i.pix_ch1),
    .bg_i      (in_data_i.bg_ch1),
    .inv_var_i (cfg_q.inv_var_ch1),
    .prod_o    (prod1)
  );

  gbrl_lane u_lane2 (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .pix_i     (in_data_i.pix_ch2),
    .bg_i      (in_data_i.bg_ch2),
    .inv_var_i (cfg_q.inv_var_ch2),
    .prod_o    (prod2)
  );

  // Merge the lanes into the per-pixel log-likelihood
  gbrl_merge u_merge (
    .clk_i          (clk_i),
    .adv_i          (adv),
    .prod0_i        (prod0),
    .prod1_i        (prod1),
    .prod2_i        (prod2),
    .log_norm_sum_i (cfg_q.log_norm_sum),
    .loglik_o       (loglik)
  );

  // Row/frame sums, raster flags and mask; holds the output register
  gbrl_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .cfg_i    (cfg_q),
    .loglik_i (loglik),
    .out_o    (out_data_o)
  );

  assign out_valid_o = v4_q;

endmodule

`default_nettype wire

FILE: test/gbrl_loglik_checker.sv
`timescale 1ns / 100ps

module gbrl_loglik_checker
  import gbrl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_t                out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  cfg_idx_e            cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatches_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  frames_o
);

  // Own copy of the register file and the raster state
  cfg_t   regs;
  int     col_pos;
  int     row_pos;
  longint row_sum;
  longint frame_sum;

  out_t   results_due[$];
  int     mismatches;
  int     checked;
  int     frames;

  function automatic longint chan_cost(logic [7:0] p, logic [7:0] b, logic [15:0] inv);
    longint d;
    d = longint'(p) - longint'(b);
    return d * d * longint'(inv);
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic int clamp_dim(logic [DimW-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return int'(lim);
    return int'(v);
  endfunction

  // Work out the result of one pixel and advance the raster state
  function automatic out_t predict_pixel_result(in_t px);
    longint cost;
    longint loglik;
    longint offset;
    longint thresh;
    int     w;
    int     h;
    logic   at_row_end;
    logic   at_frame_end;
    out_t   r;
    cost = chan_cost(px.pix_ch0, px.bg_ch0, regs.inv_var_ch0)
         + chan_cost(px.pix_ch1, px.bg_ch1, regs.inv_var_ch1)
         + chan_cost(px.pix_ch2, px.bg_ch2, regs.inv_var_ch2);
    loglik = -longint'($signed(regs.log_norm_sum)) - ((cost + longint'(RoundHalf)) >>> 8);
    offset = (regs.mode == ModeRowOffset) ? longint'(LogOffsetQ8) : longint'(0);
    thresh = longint'($signed(regs.mask_threshold));
    w = clamp_dim(regs.frame_width, MaxWidth);
    h = clamp_dim(regs.frame_height, MaxHeight);
    at_row_end = (col_pos >= w - 1);
    at_frame_end = at_row_end && (row_pos >= h - 1);
    row_sum = clip(row_sum + loglik + offset, RowAccW);
    frame_sum = clip(frame_sum + loglik, FrmAccW);
    if (regs.mode == ModeMask) begin
      r.pixel_value = (loglik < thresh) ? PixW'(MaskOn) : '0;
    end else begin
      r.pixel_value = loglik[PixW-1:0];
    end
    r.row_cumulative = row_sum[RowAccW-1:0];
    r.frame_total = frame_sum[FrmAccW-1:0];
    r.row_end = at_row_end;
    r.frame_end = at_frame_end;
    if (at_row_end) begin
      col_pos = 0;
      row_sum = 0;
      if (at_frame_end) begin
        row_pos = 0;
        frame_sum = 0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      regs.mode = ModeRowSum;
      regs.frame_width = DimW'(640);
      regs.frame_height = DimW'(480);
      regs.log_norm_sum = '0;
      regs.inv_var_ch0 = 16'd404;
      regs.inv_var_ch1 = 16'd404;
      regs.inv_var_ch2 = 16'd404;
      regs.mask_threshold = -16'sd5120;
      col_pos = 0;
      row_pos = 0;
      row_sum = 0;
      frame_sum = 0;
      results_due.delete();
      mismatches = 0;
      checked = 0;
      frames = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgMode:        regs.mode = mode_e'(cfg_data_i[1:0]);
          CfgFrameWidth:  regs.frame_width = cfg_data_i[DimW-1:0];
          CfgFrameHeight: regs.frame_height = cfg_data_i[DimW-1:0];
          CfgLogNormSum:  regs.log_norm_sum = cfg_data_i;
          CfgInvVarCh0:   regs.inv_var_ch0 = cfg_data_i;
          CfgInvVarCh1:   regs.inv_var_ch1 = cfg_data_i;
          CfgInvVarCh2:   regs.inv_var_ch2 = cfg_data_i;
          CfgMaskThresh:  regs.mask_threshold = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        want = predict_pixel_result(in_data_i);
        if (want.frame_end) frames++;
        results_due.insert(results_due.size(), want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result transfer with no pixel outstanding: %h", out_data_i);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          checked++;
          if (out_data_i.pixel_value !== want.pixel_value) begin
            $error("pixel_value: expected %0d, got %0d",
                   want.pixel_value, out_data_i.pixel_value);
            mismatches++;
          end
          if (out_data_i.row_cumulative !== want.row_cumulative) begin
            $error("row_cumulative: expected %0d, got %0d",
                   want.row_cumulative, out_data_i.row_cumulative);
            mismatches++;
          end
          if (out_data_i.frame_total !== want.frame_total) begin
            $error("frame_total: expected %0d, got %0d",
                   want.frame_total, out_data_i.frame_total);
            mismatches++;
          end
          if (out_data_i.row_end !== want.row_end) begin
            $error("row_end: expected %0d, got %0d", want.row_end, out_data_i.row_end);
            mismatches++;
          end
          if (out_data_i.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_data_i.frame_end);
            mismatches++;
          end
        end
      end
    end
    mismatches_o <= mismatches;
    pending_o <= results_due.size();
    checked_o <= checked;
    frames_o <= frames;
  end

endmodule

FILE: test/tb_gaussian_background_row_loglik.sv
`timescale 1ns / 100ps

module tb_gaussian_background_row_loglik;
  import gbrl_pkg::*;

  localparam int ResetCycles = 9;
  localparam int RandomItems = 1500;
  localparam int HoldOff     = 64;    // long output hold-off, in cycles
  localparam int TailCycles  = 8;     // tail after the final drain, in cycles
  localparam int QuietLimit  = 4000;  // cycles without any transfer before giving up

  // Every input of the block starts at a known value
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  in_t                 in_data = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_e            cfg_index = CfgMode;
  logic [CfgDataW-1:0] cfg_data = '0;

  int mismatches;
  int pending;
  int checked;
  int frames;

  int hold_req = 0;       // bump to ask the receiver for one long hold-off
  int burst_left = 0;
  int pixels_sent = 0;
  int settings_used = 0;
  int quiet = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gaussian_background_row_loglik dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  gbrl_loglik_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .frames_o     (frames)
  );

  // Offer one pixel and hold it until the block takes it. The sender runs in
  // bursts; at the start of each burst it may drop valid for a random gap.
  // Valid is only raised again in a later step than the one that dropped it.
  task automatic send_pixel(input in_t px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    burst_left--;
    pixels_sent++;
  endtask

  // Drop valid and wait until every pixel sent so far has its result back.
  // The do-while lets the checker count the final transfer before polling.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Raise the write and hold it until accepted; the caller drops valid after
  // its last write so that valid is never lowered and raised in one step.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write the whole register file; unused upper data bits sometimes carry
  // junk, which the block must ignore.
  task automatic load_settings(input cfg_t c);
    logic [CfgDataW-1:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? CfgDataW'($urandom) : '0;
    write_reg(CfgMode, {junk[CfgDataW-1:2], c.mode});
    write_reg(CfgFrameWidth, {junk[CfgDataW-1:DimW], c.frame_width});
    write_reg(CfgFrameHeight, {junk[CfgDataW-1:DimW], c.frame_height});
    write_reg(CfgLogNormSum, c.log_norm_sum);
    write_reg(CfgInvVarCh0, c.inv_var_ch0);
    write_reg(CfgInvVarCh1, c.inv_var_ch1);
    write_reg(CfgInvVarCh2, c.inv_var_ch2);
    write_reg(CfgMaskThresh, c.mask_threshold);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mix of full-range, small and extreme reciprocal variances
  function automatic logic [15:0] random_inv_var();
    case ($urandom_range(0, 3))
      0, 1:    return 16'($urandom);
      2:       return 16'($urandom_range(0, 1023));
      default: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // Receiver: stall on a pattern of its own that changes every so often, with
  // stretches of no stall at all. On request, hold off for a long stretch so
  // that the pipeline fills and the block stalls its input.
  initial begin : receiver
    int style;
    int span;
    int seen;
    seen = 0;
    forever begin
      style = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_req != seen) begin
          seen = hold_req;
          out_stall <= 1'b1;
          repeat (HoldOff) @(posedge clk);
        end
        case (style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Watchdog: give up once no channel has moved a transfer for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("tb_gaussian_background_row_loglik: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    cfg_t c;
    in_t  px;
    int   thr;
    int   phase_len;
    int   phase_no;
    int   random_sent;
    phase_no = 0;
    random_sent = 0;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Small 3 x 2 frame, default variances: zero, full and patterned differences
    c = '{mode: ModeRowSum, frame_width: 13'd3, frame_height: 13'd2,
          log_norm_sum: 16'sd0, inv_var_ch0: 16'd404, inv_var_ch1: 16'd404,
          inv_var_ch2: 16'd404, mask_threshold: -16'sd5120};
    load_settings(c);
    send_pixel(48'h000000_000000);
    send_pixel(48'hFFFFFF_000000);
    send_pixel(48'h000000_FFFFFF);
    send_pixel(48'hFFFFFF_FFFFFF);
    send_pixel(48'hAA55AA_55AA55);
    send_pixel(48'h55AA55_AA55AA);
    drain();

    // Offset mode at the largest variances and most negative normalisation
    c.mode = ModeRowOffset;
    c.frame_width = 13'd2;
    c.frame_height = 13'd1;
    c.log_norm_sum = 16'sh8000;
    c.inv_var_ch0 = 16'hFFFF;
    c.inv_var_ch1 = 16'hFFFF;
    c.inv_var_ch2 = 16'hFFFF;
    c.mask_threshold = 16'sd0;
    load_settings(c);
    send_pixel(48'hFF00FF_00FF00);
    send_pixel(48'h000000_000000);
    send_pixel(48'h00FF00_FF00FF);
    send_pixel(48'h123456_123456);
    drain();

    // Mask mode at both threshold extremes; sums still run as in mode 0
    c.mode = ModeMask;
    c.frame_width = 13'd2;
    c.frame_height = 13'd2;
    c.log_norm_sum = 16'sh7FFF;
    c.inv_var_ch0 = 16'h0000;
    c.inv_var_ch1 = 16'hFFFF;
    c.inv_var_ch2 = 16'h0001;
    c.mask_threshold = 16'sh7FFF;
    load_settings(c);
    send_pixel(48'h0000FF_FF0000);
    send_pixel(48'h808080_808080);
    drain();
    write_reg(CfgMaskThresh, 16'h8000);
    cfg_valid <= 1'b0;
    send_pixel(48'h000000_000000);
    send_pixel(48'h00FF00_000000);
    drain();

    // Spare mode behaves as mode 0; zero geometry means every pixel closes a frame
    c.mode = ModeSpare;
    c.frame_width = 13'd0;
    c.frame_height = 13'd0;
    c.log_norm_sum = 16'sd300;
    c.inv_var_ch0 = 16'd404;
    c.inv_var_ch1 = 16'd9000;
    c.inv_var_ch2 = 16'd17;
    load_settings(c);
    send_pixel(48'h0F0F0F_F0F0F0);
    send_pixel(48'hF0F0F0_0F0F0F);
    drain();

    // Oversized geometry clamps; then shrink it under the counters so the row
    // and then the frame end at once
    c.mode = ModeRowSum;
    c.frame_width = 13'd8191;
    c.frame_height = 13'd4096;
    c.log_norm_sum = 16'sd256;
    load_settings(c);
    repeat (3) send_pixel(48'h102030_405060);
    drain();
    write_reg(CfgFrameWidth, 16'd2);
    cfg_valid <= 1'b0;
    send_pixel(48'h0A0B0C_0C0B0A);
    drain();
    write_reg(CfgFrameWidth, 16'd1);
    cfg_valid <= 1'b0;
    repeat (2) send_pixel(48'h7F7F7F_807F7E);
    drain();
    write_reg(CfgFrameHeight, 16'd2);
    cfg_valid <= 1'b0;
    send_pixel(48'hC0FFEE_EEFFC0);
    drain();

    // Random phases: fresh register file each time, geometry mostly small,
    // counters carried over so shrinks under a running row also happen
    while (random_sent < RandomItems) begin
      c.mode = mode_e'($urandom_range(0, 3));
      c.frame_width = ($urandom_range(0, 9) == 0) ? DimW'($urandom_range(0, 8191))
                                                  : DimW'($urandom_range(1, 16));
      c.frame_height = ($urandom_range(0, 9) == 0) ? DimW'($urandom_range(0, 8191))
                                                   : DimW'($urandom_range(1, 6));
      c.log_norm_sum = 16'($urandom);
      c.inv_var_ch0 = random_inv_var();
      c.inv_var_ch1 = random_inv_var();
      c.inv_var_ch2 = random_inv_var();
      if ($urandom_range(0, 1) == 0) begin
        c.mask_threshold = 16'($urandom);
      end else begin
        // Place the threshold near the likely log-likelihoods so the mask toggles
        thr = -int'($signed(c.log_norm_sum)) - int'($urandom_range(0, 3000));
        if (thr > 32767) thr = 32767;
        if (thr < -32768) thr = -32768;
        c.mask_threshold = 16'(thr);
      end
      load_settings(c);

      if (phase_no == 1 || phase_no == 5) hold_req++;
      phase_len = $urandom_range(30, 150);
      repeat (phase_len) begin
        px = {16'($urandom), 32'($urandom)};
        case ($urandom_range(0, 7))
          0, 1, 2: ;
          3, 4: begin
            // background close to the image, small differences
            px.bg_ch0 = px.pix_ch0 + 8'($urandom_range(0, 6)) - 8'd3;
            px.bg_ch1 = px.pix_ch1 + 8'($urandom_range(0, 6)) - 8'd3;
            px.bg_ch2 = px.pix_ch2 + 8'($urandom_range(0, 6)) - 8'd3;
          end
          5: {px.bg_ch0, px.bg_ch1, px.bg_ch2} = {px.pix_ch0, px.pix_ch1, px.pix_ch2};
          default: begin
            // every byte at an extreme
            for (int k = 0; k < 48; k += 8) begin
              px[k +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            end
          end
        endcase
        send_pixel(px);
        random_sent++;
      end
      drain();
      phase_no++;
    end

    // All results are in; let the tail pass to catch stray transfers
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d pixels under %0d register settings, %0d results checked, %0d frames.",
             pixels_sent, settings_used, checked, frames);
    $display("Modes 0-3, zero and clamped geometry, shrinks under a running row/frame, %0d-cycle hold-off.",
             HoldOff);
    if (mismatches == 0) begin
      $display("tb_gaussian_background_row_loglik: PASS");
    end else begin
      $display("tb_gaussian_background_row_loglik: FAIL");
    end
    $finish;
  end

endmodule
